[design/mvt_pkg.sv]
// ============================================================================
// mvt_pkg: shared types and constants of the 4x4 matrix-vector transform
// Word and fraction widths, matrix and product array types, opcode codes
// and the matrix write-port bundle.
// ============================================================================
package mvt_pkg;

    // Fixed-point format of matrix entries, vector components and results.
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_BITS = 32;

    // Working word width: never wider than the 32-bit port fields.
    localparam int EFF_BITS   = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int PROD_BITS  = 2 * EFF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int SHIFT_BITS = SUM_BITS - FRAC_BITS;
    localparam int DIM        = 4;
    localparam int IDX_BITS   = $clog2(DIM);

    // Largest and smallest word values, sign-extended to the port width.
    localparam logic signed [FIELD_BITS-1:0] W_MAX =
        FIELD_BITS'((64'sd1 <<< (EFF_BITS - 1)) - 64'sd1);
    localparam logic signed [FIELD_BITS-1:0] W_MIN =
        FIELD_BITS'(-(64'sd1 <<< (EFF_BITS - 1)));

    typedef logic signed [EFF_BITS-1:0]  t_word;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [FIELD_BITS-1:0] t_field;

    typedef t_word [DIM-1:0] t_vec;
    typedef t_vec  [DIM-1:0] t_mat;
    typedef t_prod [DIM-1:0] t_prod_row;
    typedef t_prod_row [DIM-1:0] t_prod_mat;
    typedef t_field [DIM-1:0] t_field_vec;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_opcode;

    // Write port of the matrix store.
    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        t_word               data;
    } t_mat_wr;

endpackage

[design/mvt_mat_store.sv]
// ============================================================================
// mvt_mat_store: 4x4 matrix register file
// Sixteen signed words, cleared at reset, one entry written per cycle,
// every entry visible at once to the multiplier array.
// ============================================================================
module mvt_mat_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mvt_pkg::t_mat_wr i_wr,
    output mvt_pkg::t_mat   o_mat
);
    import mvt_pkg::*;

    t_mat r_mat;

    // Clear on reset; otherwise write the addressed entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (i_wr.en) begin
            r_mat[i_wr.row][i_wr.col] <= i_wr.data;
        end
    end

    assign o_mat = r_mat;

endmodule

[design/mvt_mul_stage.sv]
// ============================================================================
// mvt_mul_stage: sixteen parallel multipliers
// Forms every matrix entry times its vector component and registers the
// full-precision products.
// ============================================================================
module mvt_mul_stage (
    input  logic               i_clk,
    input  logic               i_en,
    input  mvt_pkg::t_mat      i_mat,
    input  mvt_pkg::t_vec      i_vec,
    output mvt_pkg::t_prod_mat o_prod
);
    import mvt_pkg::*;

    t_prod_mat n_prod;
    t_prod_mat r_prod;

    // One exact signed product per matrix entry.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                n_prod[r][c] = $signed(i_mat[r][c]) * $signed(i_vec[c]);
            end
        end
    end

    // Product register, loaded whenever the next stage can take a beat.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[design/mvt_sum_sat.sv]
// ============================================================================
// mvt_sum_sat: row sums, truncation and saturation
// Adds the four products of each row, drops the fraction bits toward minus
// infinity, clips to the word range and registers the result beat.
// ============================================================================
module mvt_sum_sat (
    input  logic                i_clk,
    input  logic                i_en,
    input  mvt_pkg::t_prod_mat  i_prod,
    output mvt_pkg::t_field_vec o_res,
    output logic                o_sat
);
    import mvt_pkg::*;

    logic signed [SUM_BITS-1:0]   sum   [DIM];
    logic signed [SHIFT_BITS-1:0] shft  [DIM];
    logic [DIM-1:0]               ovf;
    t_field_vec                   n_res;
    t_field_vec                   r_res;
    logic                         r_sat;

    // Exact row sum, then an arithmetic shift by the fraction width.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            sum[r] = SUM_BITS'($signed(i_prod[r][0])) + SUM_BITS'($signed(i_prod[r][1]))
                   + SUM_BITS'($signed(i_prod[r][2])) + SUM_BITS'($signed(i_prod[r][3]));
            shft[r] = $signed(sum[r][SUM_BITS-1:FRAC_BITS]);
        end
    end

    // Clip to the word range when the upper bits are not a pure sign run.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            ovf[r] = (shft[r][SHIFT_BITS-1:EFF_BITS-1] != '0) &&
                     (shft[r][SHIFT_BITS-1:EFF_BITS-1] != '1);
            if (!ovf[r]) begin
                n_res[r] = FIELD_BITS'(t_word'(shft[r]));
            end else if (shft[r][SHIFT_BITS-1]) begin
                n_res[r] = W_MIN;
            end else begin
                n_res[r] = W_MAX;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_sat <= |ovf;
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

[design/matrix_vector_transform_4x4_unit.sv]
// ============================================================================
// matrix_vector_transform_4x4_unit: 4x4 fixed-point matrix-vector transform
// Holds a signed Q16.16 matrix; load beats write one entry, transform beats
// return the saturated product of the matrix with a homogeneous vector.
// ============================================================================
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-----------------------------------
//  input   | i_in_valid / o_in_ready    | i_opcode, i_entry_*, i_vec_*
//  output  | o_out_valid / i_out_ready  | o_out_x/y/z/w, o_saturated
//
// One beat is taken every cycle while o_in_ready is high. A transform beat
// passes through the input, product and result registers in that order,
// and its result is valid once it reaches the result register. A load beat
// gives no result and writes the matrix from the input register, so later
// transforms see it. Reset clears the matrix and all valid flags. A stalled
// output only holds the full stages behind it; empty stages keep taking beats.
//
module matrix_vector_transform_4x4_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic [1:0]             i_entry_row,
    input  logic [1:0]             i_entry_col,
    input  logic signed [31:0]     i_entry_value,
    input  logic signed [31:0]     i_vec_x,
    input  logic signed [31:0]     i_vec_y,
    input  logic signed [31:0]     i_vec_z,
    input  logic signed [31:0]     i_vec_w,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [31:0]     o_out_x,
    output logic signed [31:0]     o_out_y,
    output logic signed [31:0]     o_out_z,
    output logic signed [31:0]     o_out_w,
    output logic                   o_saturated
);
    import mvt_pkg::*;

    // Input register.
    logic                r_s1_valid;
    t_opcode             r_s1_op;
    logic [IDX_BITS-1:0] r_s1_row;
    logic [IDX_BITS-1:0] r_s1_col;
    t_word               r_s1_value;
    t_vec                r_s1_vec;

    logic       r_s2_valid;
    logic       r_s3_valid;
    logic       s1_ready;
    logic       s2_ready;
    logic       s3_ready;
    t_mat_wr    mat_wr;
    t_mat       mat;
    t_prod_mat  prod;
    t_field_vec res;

    // Stage readiness: a load never needs the later stages.
    assign s3_ready   = !r_s3_valid || i_out_ready;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_ready   = !r_s1_valid || (r_s1_op == OP_LOAD) || s2_ready;
    assign o_in_ready = s1_ready;

    // Valid flags of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid && (r_s1_op == OP_XFORM);
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // Input payload register, words cut to the working width.
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_op     <= t_opcode'(i_opcode);
            r_s1_row    <= i_entry_row;
            r_s1_col    <= i_entry_col;
            r_s1_value  <= t_word'(i_entry_value);
            r_s1_vec[0] <= t_word'(i_vec_x);
            r_s1_vec[1] <= t_word'(i_vec_y);
            r_s1_vec[2] <= t_word'(i_vec_z);
            r_s1_vec[3] <= t_word'(i_vec_w);
        end
    end

    // Matrix write from a load beat in the input register.
    always_comb begin
        mat_wr.en   = r_s1_valid && (r_s1_op == OP_LOAD);
        mat_wr.row  = r_s1_row;
        mat_wr.col  = r_s1_col;
        mat_wr.data = r_s1_value;
    end

    mvt_mat_store u_mat_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mat_wr),
        .o_mat   (mat)
    );

    mvt_mul_stage u_mul_stage (
        .i_clk  (i_clk),
        .i_en   (s2_ready),
        .i_mat  (mat),
        .i_vec  (r_s1_vec),
        .o_prod (prod)
    );

    mvt_sum_sat u_sum_sat (
        .i_clk (i_clk),
        .i_en  (s3_ready),
        .i_prod(prod),
        .o_res (res),
        .o_sat (o_saturated)
    );

    assign o_out_valid = r_s3_valid;
    assign o_out_x     = res[0];
    assign o_out_y     = res[1];
    assign o_out_z     = res[2];
    assign o_out_w     = res[3];

    // A load beat in the input register always retires in the same cycle.
    a_load_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_op == OP_LOAD)) |-> s1_ready)
        else $error("load beat held in input register");

    // A product beat blocked by a full result stage stays in place.
    a_s2_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s3_ready) |=> r_s2_valid)
        else $error("product beat lost under stall");

    // A saturated result has at least one component at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_out_x == W_MAX || o_out_x == W_MIN || o_out_y == W_MAX || o_out_y == W_MIN ||
             o_out_z == W_MAX || o_out_z == W_MIN || o_out_w == W_MAX || o_out_w == W_MIN))
        else $error("saturation flag without clipped component");

endmodule

[test/tb_matrix_vector_transform_4x4_unit.sv]
// ============================================================================
// tb_matrix_vector_transform_4x4_unit: self-checking bench of the transform
// Loads matrix entries and pushes vectors through the unit. A shadow copy of
// the matrix predicts every transform result, and each result beat is
// checked field by field. Both channels idle and stall at random.
// ============================================================================
module tb_matrix_vector_transform_4x4_unit;

    import mvt_pkg::*;

    // One command for the input channel; unused fields carry random noise.
    typedef struct {
        t_opcode    op;
        logic [1:0] row;
        logic [1:0] col;
        t_field     value;
        t_field     vec [4];
    } t_xform_cmd;

    // One predicted transform result.
    typedef struct {
        t_field comp [4];
        logic   sat;
    } t_vec_result;

    localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;
    localparam int CHUNK_ITEMS = 350;
    localparam int CHUNK_COUNT = 5;
    localparam int PRINT_LIMIT = 40;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_ready;
    logic   i_opcode = 1'b0;
    logic [1:0] i_entry_row = '0;
    logic [1:0] i_entry_col = '0;
    t_field i_entry_value = '0;
    t_field i_vec_x = '0;
    t_field i_vec_y = '0;
    t_field i_vec_z = '0;
    t_field i_vec_w = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_field o_out_x;
    t_field o_out_y;
    t_field o_out_z;
    t_field o_out_w;
    logic   o_saturated;

    t_xform_cmd  cmd_queue [$];
    t_vec_result expected_vecs [$];
    t_field      shadow_matrix [16];
    logic        in_beat = 1'b0;
    int          error_count = 0;
    string       comp_name [4] = '{"x", "y", "z", "w"};

    matrix_vector_transform_4x4_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_entry_row   (i_entry_row),
        .i_entry_col   (i_entry_col),
        .i_entry_value (i_entry_value),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_vec_w       (i_vec_w),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_w       (o_out_w),
        .o_saturated   (o_saturated)
    );

    // Clock with a period of four time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Prints one line for the first failures and counts all of them.
    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("MISMATCH: %s", msg);
        end
        error_count++;
    endtask

    // Exact dot product of each matrix row with the vector, floored back to
    // sixteen fraction bits, then clipped to the 32-bit range.
    function automatic t_vec_result transform_vector(t_field vx, t_field vy,
                                                     t_field vz, t_field vw);
        t_field             vec [4];
        logic signed [65:0] acc;
        logic signed [65:0] shifted;
        t_vec_result        res;
        int                 r;
        int                 c;
        vec = '{vx, vy, vz, vw};
        res.sat = 1'b0;
        for (r = 0; r < 4; r++) begin
            acc = '0;
            for (c = 0; c < 4; c++) begin
                acc = acc + shadow_matrix[r * 4 + c] * vec[c];
            end
            shifted = acc >>> 16;
            if (shifted > SUM_MAX) begin
                res.comp[r] = t_field'(SUM_MAX);
                res.sat = 1'b1;
            end else if (shifted < SUM_MIN) begin
                res.comp[r] = t_field'(SUM_MIN);
                res.sat = 1'b1;
            end else begin
                res.comp[r] = t_field'(shifted);
            end
        end
        return res;
    endfunction

    // Random fixed-point word: mostly small values, some full range, some
    // corner values.
    function automatic t_field rand_q16();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 6))
                0: return 32'sh7fff_ffff;
                1: return 32'sh8000_0000;
                2: return 32'sh0000_0000;
                3: return 32'shffff_ffff;
                4: return 32'sh0000_0001;
                5: return 32'sh0001_0000;
                default: return 32'shffff_0000;
            endcase
        end else if (pick < 3) begin
            return t_field'($urandom);
        end
        return t_field'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    // Gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic queue_load(input logic [1:0] row, input logic [1:0] col,
                              input t_field value);
        t_xform_cmd cmd;
        int         i;
        cmd.op = OP_LOAD;
        cmd.row = row;
        cmd.col = col;
        cmd.value = value;
        for (i = 0; i < 4; i++) begin
            cmd.vec[i] = t_field'($urandom);
        end
        cmd_queue.insert(cmd_queue.size(), cmd);
    endtask

    task automatic queue_xform(input t_field vx, input t_field vy,
                               input t_field vz, input t_field vw);
        t_xform_cmd cmd;
        cmd.op = OP_XFORM;
        cmd.row = 2'($urandom);
        cmd.col = 2'($urandom);
        cmd.value = t_field'($urandom);
        cmd.vec = '{vx, vy, vz, vw};
        cmd_queue.insert(cmd_queue.size(), cmd);
    endtask

    // Waits until every queued beat is taken and every result has come.
    task automatic drain();
        while (cmd_queue.size() != 0 || i_in_valid || expected_vecs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Input driver: presents the next command once the previous beat is
    // taken, with random gaps and occasional stretches without gaps.
    always @(negedge i_clk) begin : cmd_driver
        int         gap_left;
        int         calm_left;
        t_xform_cmd cmd;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (cmd_queue.size() > 0) begin
                cmd = cmd_queue.pop_front();
                i_in_valid    <= 1'b1;
                i_opcode      <= cmd.op;
                i_entry_row   <= cmd.row;
                i_entry_col   <= cmd.col;
                i_entry_value <= cmd.value;
                i_vec_x       <= cmd.vec[0];
                i_vec_y       <= cmd.vec[1];
                i_vec_z       <= cmd.vec[2];
                i_vec_w       <= cmd.vec[3];
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 59) == 0) begin
                    calm_left = $urandom_range(40, 120);
                end else begin
                    gap_left = pick_gap();
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall driver: random stalls with calm stretches in between.
    always @(negedge i_clk) begin : ready_driver
        int stall_left;
        int calm_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 59) == 0) begin
                calm_left = $urandom_range(40, 120);
            end else if ($urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // Monitor: checks result beats, then updates the shadow matrix or
    // predicts a result for each accepted input beat.
    always @(posedge i_clk) begin : beat_monitor
        t_vec_result want;
        t_field      got [4];
        int          r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_vecs.size() == 0) begin
                report_mismatch("result beat with no transform outstanding");
            end else begin
                want = expected_vecs.pop_front();
                got = '{o_out_x, o_out_y, o_out_z, o_out_w};
                for (r = 0; r < 4; r++) begin
                    if (got[r] !== want.comp[r]) begin
                        report_mismatch($sformatf("out_%s: got %h, expected %h",
                                                  comp_name[r], got[r], want.comp[r]));
                    end
                end
                if (o_saturated !== want.sat) begin
                    report_mismatch($sformatf("saturated: got %b, expected %b",
                                              o_saturated, want.sat));
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_opcode == OP_LOAD) begin
                shadow_matrix[{i_entry_row, i_entry_col}] = i_entry_value;
            end else begin
                expected_vecs.insert(expected_vecs.size(),
                                     transform_vector(i_vec_x, i_vec_y,
                                                      i_vec_z, i_vec_w));
            end
        end
        in_beat <= i_rst_n && i_in_valid && o_in_ready;
    end

    // Stimulus: directed corners first, then random chunks with a full
    // drain between them.
    initial begin : stimulus
        int n;
        int k;
        int chunk;
        for (k = 0; k < 16; k++) begin
            shadow_matrix[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The matrix is all zero after reset.
        queue_xform(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        // Identity passes extreme components through unchanged.
        for (k = 0; k < 4; k++) begin
            queue_load(k[1:0], k[1:0], 32'sh0001_0000);
        end
        queue_xform(32'sh7fff_ffff, 32'sh8000_0000, 32'shffff_ffff, 32'sh0000_0001);
        queue_xform(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'sh1234_5678);
        // Large entries drive row 0 past the top and row 1 past the bottom.
        queue_load(2'd0, 2'd0, 32'sh7fff_ffff);
        queue_load(2'd0, 2'd1, 32'sh7fff_ffff);
        queue_load(2'd1, 2'd1, 32'sh8000_0000);
        queue_xform(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0001_0000, 32'sh0000_0000);
        // Half times a tiny negative value floors toward minus infinity.
        queue_load(2'd3, 2'd3, 32'sh0000_8000);
        queue_xform(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0003, 32'shffff_ffff);
        // A row of smallest entries against a vector of smallest components
        // gives the widest possible sum.
        for (k = 0; k < 4; k++) begin
            queue_load(2'd2, k[1:0], 32'sh8000_0000);
        end
        queue_xform(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        queue_xform(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        drain();

        for (chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
            n = 0;
            while (n < CHUNK_ITEMS) begin
                if ($urandom_range(0, 39) == 0) begin
                    // Reload the whole matrix, then use it.
                    for (k = 0; k < 16; k++) begin
                        queue_load(k[3:2], k[1:0], rand_q16());
                    end
                    n += 16;
                end else if ($urandom_range(0, 9) < 3) begin
                    queue_load(2'($urandom), 2'($urandom), rand_q16());
                    n++;
                end else begin
                    queue_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
                    n++;
                end
            end
            // The sender holds off until every outstanding result is back.
            drain();
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[matrix_vector_transform_4x4_unit.f]
design/mvt_pkg.sv
design/mvt_mat_store.sv
design/mvt_mul_stage.sv
design/mvt_sum_sat.sv
design/matrix_vector_transform_4x4_unit.sv
test/tb_matrix_vector_transform_4x4_unit.sv
